>>> rtl/bdsl_pkg.sv
// ----------------------------------------------------------------------------
// bdsl_pkg
// Shared types and constants for the button debouncer with short/long press.
// ----------------------------------------------------------------------------
package bdsl_pkg;

  localparam int unsigned CFG_AW = 3;   // two 32-bit registers at 0x0, 0x4
  localparam int unsigned CFG_DW = 32;

  // Register index (paddr[2])
  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;

  localparam logic [15:0] DB_WINDOW_RST   = 16'd30;
  localparam logic [15:0] LONG_THRESH_RST = 16'd700;

  // Event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  // Request kinds
  localparam logic KIND_TAKE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [15:0] db_window;
    logic [15:0] long_thresh;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic        raw_pressed;
    logic [31:0] now_ms;
  } item_t;

endpackage

>>> rtl/bdsl_if.sv
// ----------------------------------------------------------------------------
// bdsl_in_if / bdsl_out_if
// Valid/ready channels for poll requests and results.
// ----------------------------------------------------------------------------
interface bdsl_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        raw_pressed;
  logic [31:0] now_ms;

  modport source (output valid, kind, raw_pressed, now_ms, input ready);
  modport sink   (input valid, kind, raw_pressed, now_ms, output ready);
endinterface

interface bdsl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       level;

  modport source (output valid, event_res, level, input ready);
  modport sink   (input valid, event_res, level, output ready);
endinterface

>>> rtl/button_debounce_short_long_top.sv
// ----------------------------------------------------------------------------
// button_debounce_short_long_top
// Push-button debouncer with short/long press events, one poll per cycle while results are taken.
// ----------------------------------------------------------------------------
// Each request is one poll of the button: raw level, a free-running ms
// timestamp and a kind (0 takes the queued event, 1 only reads the level).
// Every request yields exactly one result carrying the taken event
// (none/short/long) and the debounced level after that poll. A request is
// registered on entry, then the debounce/long-press logic (two 32-bit
// wrapping subtract-compares) updates the button state and loads the result
// register at the next edge once the request has left the entry register;
// a new request is taken every cycle as long as the result
// side keeps up. The result register and the entry register each hold one
// request, so a stalled result still lets one more request in. Only one
// event is queued; a newer one overwrites an untaken one. Registers (APB,
// byte address 0x0 debounce window, 0x4 long-press threshold, 16 bits each,
// in ms, reset 30 and 700) should be written only while no request is in
// flight.
// ----------------------------------------------------------------------------
module button_debounce_short_long_top (
  input  logic                        clk,
  input  logic                        rst_n,
  bdsl_in_if.sink                     in_ch,
  bdsl_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdsl_pkg::CFG_AW-1:0] paddr,
  input  logic [bdsl_pkg::CFG_DW-1:0] pwdata,
  output logic [bdsl_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  bdsl_pkg::cfg_t  cfg;
  bdsl_pkg::item_t in_item_r;
  logic            in_vld_r;
  logic            in_vld_nxt;
  logic            take;     // poll stage accepts the registered request
  logic            in_acc;   // new request enters the entry register

  bdsl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // entry register: free, or draining into the poll stage this cycle
  assign in_ch.ready = !in_vld_r || take;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take) begin
      in_vld_nxt = 1'b0;
    end
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r.kind        <= in_ch.kind;
      in_item_r.raw_pressed <= in_ch.raw_pressed;
      in_item_r.now_ms      <= in_ch.now_ms;
    end
  end

  logic poll_ready;

  bdsl_poll u_poll (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_vld_r),
    .item       (in_item_r),
    .item_ready (poll_ready),
    .out_ch     (out_ch)
  );

  assign take = in_vld_r && poll_ready;

endmodule

>>> rtl/bdsl_cfg.sv
// ----------------------------------------------------------------------------
// bdsl_cfg
// APB-style register file: debounce window and long-press threshold.
// ----------------------------------------------------------------------------
module bdsl_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bdsl_pkg::CFG_AW-1:0] paddr,
  input  logic [bdsl_pkg::CFG_DW-1:0] pwdata,
  output logic [bdsl_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output bdsl_pkg::cfg_t             cfg
);

  bdsl_pkg::cfg_t cfg_r;
  bdsl_pkg::cfg_t cfg_nxt;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[2])
        bdsl_pkg::REG_DEBOUNCE:   cfg_nxt.db_window   = pwdata[15:0];
        bdsl_pkg::REG_LONG_PRESS: cfg_nxt.long_thresh = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.db_window   <= bdsl_pkg::DB_WINDOW_RST;
      cfg_r.long_thresh <= bdsl_pkg::LONG_THRESH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      bdsl_pkg::REG_DEBOUNCE:   prdata = {16'd0, cfg_r.db_window};
      bdsl_pkg::REG_LONG_PRESS: prdata = {16'd0, cfg_r.long_thresh};
      default:                  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/bdsl_poll.sv
// ----------------------------------------------------------------------------
// bdsl_poll
// Debounce state, press classification and result register.
// ----------------------------------------------------------------------------
module bdsl_poll (
  input  logic               clk,
  input  logic               rst_n,
  input  bdsl_pkg::cfg_t     cfg,
  input  logic               item_valid,
  input  bdsl_pkg::item_t    item,
  output logic               item_ready,
  bdsl_out_if.source         out_ch
);

  logic        last_raw_r,     last_raw_nxt;
  logic        stable_r,       stable_nxt;
  logic [31:0] change_time_r,  change_time_nxt;
  logic [31:0] press_time_r,   press_time_nxt;
  logic        long_done_r,    long_done_nxt;
  logic [1:0]  pend_r,         pend_nxt;
  logic        out_vld_r,      out_vld_nxt;
  logic [1:0]  out_ev_r,       out_ev_nxt;
  logic        out_lvl_r,      out_lvl_nxt;

  logic        adv;
  logic        raw_chg;
  logic [31:0] el_chg;
  logic [31:0] el_press;
  logic        deb_ok;
  logic        flip;
  logic        rise;
  logic        fall;
  logic        long_ok;
  logic        long_done_a;
  logic [1:0]  pend_a;
  logic        fire;

  assign item_ready = !out_vld_r || out_ch.ready;
  assign adv        = item_valid && item_ready;

  // elapsed times, 32-bit wrapping
  assign raw_chg  = item.raw_pressed != last_raw_r;
  assign el_chg   = item.now_ms - change_time_r;
  assign el_press = item.now_ms - press_time_r;

  // a fresh raw change restarts the window at zero elapsed
  assign deb_ok = raw_chg ? (cfg.db_window == 16'd0)
                          : (el_chg >= {16'd0, cfg.db_window});
  assign flip   = (item.raw_pressed != stable_r) && deb_ok;
  assign rise   = flip && item.raw_pressed;
  assign fall   = flip && !item.raw_pressed;

  assign stable_nxt  = (adv && flip) ? item.raw_pressed : stable_r;
  assign long_done_a = rise ? 1'b0 : long_done_r;
  assign pend_a      = (fall && !long_done_r) ? bdsl_pkg::EV_SHORT : pend_r;

  // press starting on this poll: elapsed is zero
  assign long_ok = rise ? (cfg.long_thresh == 16'd0)
                        : (el_press >= {16'd0, cfg.long_thresh});
  assign fire    = stable_nxt && !long_done_a && long_ok;

  always_comb begin
    last_raw_nxt    = last_raw_r;
    change_time_nxt = change_time_r;
    press_time_nxt  = press_time_r;
    long_done_nxt   = long_done_r;
    pend_nxt        = pend_r;
    out_ev_nxt      = out_ev_r;
    out_lvl_nxt     = out_lvl_r;
    out_vld_nxt     = out_vld_r;

    if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (adv) begin
      last_raw_nxt    = item.raw_pressed;
      change_time_nxt = raw_chg ? item.now_ms : change_time_r;
      press_time_nxt  = rise ? item.now_ms : press_time_r;
      long_done_nxt   = fire ? 1'b1 : long_done_a;
      pend_nxt        = fire ? bdsl_pkg::EV_LONG : pend_a;
      out_ev_nxt      = bdsl_pkg::EV_NONE;
      if (item.kind == bdsl_pkg::KIND_TAKE) begin
        out_ev_nxt = pend_nxt;
        pend_nxt   = bdsl_pkg::EV_NONE;
      end
      out_lvl_nxt = stable_nxt;
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= 1'b0;
      stable_r      <= 1'b0;
      change_time_r <= '0;
      press_time_r  <= '0;
      long_done_r   <= 1'b0;
      pend_r        <= bdsl_pkg::EV_NONE;
      out_vld_r     <= 1'b0;
    end else begin
      last_raw_r    <= last_raw_nxt;
      stable_r      <= stable_nxt;
      change_time_r <= change_time_nxt;
      press_time_r  <= press_time_nxt;
      long_done_r   <= long_done_nxt;
      pend_r        <= pend_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ev_r  <= out_ev_nxt;
    out_lvl_r <= out_lvl_nxt;
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.event_res = out_ev_r;
  assign out_ch.level     = out_lvl_r;

`ifndef ASSERT_OFF
  // once a hold is reported long, its release must not queue a short
  a_long_no_short: assert property (@(posedge clk) disable iff (!rst_n)
    long_done_r |-> (pend_r != bdsl_pkg::EV_SHORT))
    else $error("short event queued after long press");

  // a query-only request never returns an event
  a_query_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item.kind == bdsl_pkg::KIND_QUERY) |=> (out_ev_r == bdsl_pkg::EV_NONE))
    else $error("query request returned an event");

  // a taken event clears the queue
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item.kind == bdsl_pkg::KIND_TAKE) |=> (pend_r == bdsl_pkg::EV_NONE))
    else $error("event still queued after take");

  // a new press rearms long detection (checked for a nonzero long-press threshold)
  a_press_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && rise && cfg.long_thresh != 16'd0) |=> !long_done_r)
    else $error("long flag set on fresh press");
`endif

endmodule
